// ----- sv/lspx_pkg.sv -----
// Shared constants and elaboration-time helpers for the lidar point-to-xyz pipeline.
// Holds the CORDIC arctangent table and the elevation tangent builder.
// No dependencies.
package lspx_pkg;

    localparam int LAYERS_DEF   = 8;
    localparam int CORDIC_STEPS = 28;
    localparam int DIV_STEPS    = 48;
    localparam logic [15:0] TPR_RESET = 16'd11520;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [27:0] POS_MAX = 28'sd16777215;
    localparam logic signed [27:0] POS_MIN = -28'sd16777216;

    // arctan(2^-i) as a fraction of a full turn, 2^32 per turn
    function automatic logic signed [32:0] atan_phase(input int i);
        logic signed [32:0] r;
        case (i)
            0:       r = 33'sd536870912;
            1:       r = 33'sd316933406;
            2:       r = 33'sd167458907;
            3:       r = 33'sd85004756;
            4:       r = 33'sd42667331;
            5:       r = 33'sd21354465;
            6:       r = 33'sd10680862;
            7:       r = 33'sd5340245;
            8:       r = 33'sd2670163;
            9:       r = 33'sd1335087;
            10:      r = 33'sd667544;
            11:      r = 33'sd333772;
            12:      r = 33'sd166886;
            13:      r = 33'sd83443;
            14:      r = 33'sd41722;
            15:      r = 33'sd20861;
            16:      r = 33'sd10430;
            17:      r = 33'sd5215;
            18:      r = 33'sd2608;
            19:      r = 33'sd1304;
            20:      r = 33'sd652;
            21:      r = 33'sd326;
            22:      r = 33'sd163;
            23:      r = 33'sd81;
            24:      r = 33'sd41;
            25:      r = 33'sd20;
            26:      r = 33'sd10;
            27:      r = 33'sd5;
            default: r = 33'sd0;
        endcase
        return r;
    endfunction

    // Q30 tangent of n * 0.4 degrees, built with the same CORDIC as the datapath
    function automatic longint tan_q30(input int n);
        longint mag;
        longint p;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint c;
        longint s;
        logic [31:0] ph;
        logic [31:0] u;
        logic [1:0] q;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        logic nneg;
        mag = (n < 0) ? -longint'(n) : longint'(n);
        p = ((mag * 2) <<< 32) + 900;
        p = p / 1800;
        ph = p[31:0];
        if (n < 0)
        begin
            ph = -ph;
        end
        q = 2'((ph + 32'h2000_0000) >> 30);
        u = ph - {q, 30'd0};
        z = longint'(signed'(u));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_phase(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_phase(i));
            end
        end
        case (q)
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        if (c == 0)
        begin
            return 0;
        end
        nneg = (s < 0) != (c < 0);
        a = 64'((s < 0) ? -s : s) << 30;
        b = 64'((c < 0) ? -c : c);
        num = a + (b >> 1);
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--)
        begin
            rem = {rem[62:0], num[j]};
            if (rem >= b)
            begin
                rem = rem - b;
                quo[j] = 1'b1;
            end
        end
        return nneg ? -longint'(quo) : longint'(quo);
    endfunction

endpackage

// ----- sv/lidar_scan_point_to_xyz.sv -----
// Lidar scan point to x/y/z: pipelined phase divider, CORDIC and output scaling.
// Depends on lspx_pkg (constants, arctangent table, tangent table builder).
//
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+-----------------
//  in      | horizontal_ticks, distance_cm, layer, scan_flags| in_valid/in_ready
//  out     | pos_x, pos_y, pos_z                            | out_valid/out_ready
//  cfg     | cfg_wdata (ticks per rotation)                 | cfg_we, no wait
//
// One word per cycle while output is taken; stages: 1 input stage, 48 stages of
// the one-bit-per-stage phase divider, 1 quadrant stage, 28 CORDIC stages, rotate,
// multiply and round/saturate. All stages hold together while the output word is
// not taken; bubbles inside the pipeline are held too, not squeezed out.
// Reset clears stage valid bits and loads 11520 ticks per rotation.
module lidar_scan_point_to_xyz #(
    parameter int LAYERS = lspx_pkg::LAYERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] horizontal_ticks,
    input  logic [15:0]        distance_cm,
    input  logic [2:0]         layer,
    input  logic [15:0]        scan_flags,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [24:0] pos_x,
    output logic signed [24:0] pos_y,
    output logic signed [24:0] pos_z
);

    localparam int NDIV  = lspx_pkg::DIV_STEPS;
    localparam int NCOR  = lspx_pkg::CORDIC_STEPS;
    localparam int S_PH  = NDIV + 1;
    localparam int S_ROT = S_PH + NCOR + 1;
    localparam int S_MUL = S_ROT + 1;
    localparam int S_OUT = S_MUL + 1;
    localparam int NTAB  = 2 * LAYERS;
    localparam int TIDX_W = (NTAB > 1) ? $clog2(NTAB) : 1;

    logic              advance;
    logic              v_reg [0:S_OUT];
    logic [15:0]       den_reg;
    logic [31:0]       half32;

    logic [15:0]       dist_reg [0:S_ROT];
    logic signed [31:0] tanf_reg [0:S_ROT];
    logic [15:0]       tmag_reg [0:15];
    logic              tneg_reg [0:NDIV];
    logic [15:0]       rem_reg  [0:NDIV];
    logic [31:0]       quo_reg  [0:NDIV];

    logic signed [32:0] cx_reg [0:NCOR];
    logic signed [32:0] cy_reg [0:NCOR];
    logic signed [32:0] cz_reg [0:NCOR];
    logic [1:0]         quad_reg [0:NCOR];

    logic signed [32:0] fc_reg;
    logic signed [32:0] fs_reg;
    logic signed [49:0] px_reg;
    logic signed [49:0] py_reg;
    logic signed [49:0] pz_reg;
    logic signed [24:0] pos_x_reg;
    logic signed [24:0] pos_y_reg;
    logic signed [24:0] pos_z_reg;

    logic signed [31:0] tan_tab [NTAB];
    logic [TIDX_W-1:0]  tidx;
    int                 li;
    int                 ti;

    assign advance   = !v_reg[S_OUT] || out_ready;
    assign in_ready  = advance;
    assign out_valid = v_reg[S_OUT];
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign half32    = {17'd0, den_reg[15:1]};

    // tangent table: lower mirror side first, then upper
    for (genvar g = 0; g < NTAB; g++)
    begin : g_tan
        localparam int N = (g >= LAYERS) ? 2 * (g - LAYERS) + 1 : 2 * g - 7;
        localparam longint TV = lspx_pkg::tan_q30(N);
        assign tan_tab[g] = TV[31:0];
    end

    always_comb
    begin
        li = (int'(layer) >= LAYERS) ? LAYERS - 1 : int'(layer);
        ti = (scan_flags[10] ? LAYERS : 0) + li;
        tidx = ti[TIDX_W-1:0];
    end

    // a zero count behaves as one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            den_reg <= lspx_pkg::TPR_RESET;
        end
        else if (cfg_we)
        begin
            den_reg <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= S_OUT; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= S_OUT; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // input stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tneg_reg[0] <= horizontal_ticks[15];
            tmag_reg[0] <= horizontal_ticks[15] ? 16'(-horizontal_ticks)
                                                : 16'(horizontal_ticks);
            dist_reg[0] <= distance_cm;
            tanf_reg[0] <= tan_tab[tidx];
            rem_reg[0]  <= '0;
            quo_reg[0]  <= '0;
        end
    end

    // carry distance and tangent factor to the rotate stage
    for (genvar s = 0; s < S_ROT; s++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dist_reg[s+1] <= dist_reg[s];
                tanf_reg[s+1] <= tanf_reg[s];
            end
        end
    end

    // restoring divider: (tmag * 2^32 + den/2) / den, one quotient bit per stage
    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        logic        nb;
        logic [16:0] r2;
        logic        ge;
        logic [16:0] diff;

        if (k < 16)
        begin : g_hi
            assign nb = tmag_reg[k][15-k];
            if (k < 15)
            begin : g_tm
                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        tmag_reg[k+1] <= tmag_reg[k];
                    end
                end
            end
        end
        else
        begin : g_lo
            assign nb = half32[47-k];
        end

        assign r2   = {rem_reg[k], nb};
        assign ge   = r2 >= {1'b0, den_reg};
        assign diff = r2 - {1'b0, den_reg};

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k+1]  <= ge ? diff[15:0] : r2[15:0];
                quo_reg[k+1]  <= {quo_reg[k][30:0], ge};
                tneg_reg[k+1] <= tneg_reg[k];
            end
        end
    end

    // quadrant reduction, residual within +-45 degrees
    logic [31:0] phase;
    logic [31:0] ph_bias;
    logic [1:0]  quad;
    logic [31:0] resid;

    always_comb
    begin
        phase   = tneg_reg[NDIV] ? -quo_reg[NDIV] : quo_reg[NDIV];
        ph_bias = phase + 32'h2000_0000;
        quad    = ph_bias[31:30];
        resid   = phase - {quad, 30'd0};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg[0]   <= lspx_pkg::CORDIC_GAIN;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= {resid[31], resid};
            quad_reg[0] <= quad;
        end
    end

    for (genvar i = 0; i < NCOR; i++)
    begin : g_cordic
        logic signed [32:0] dx;
        logic signed [32:0] dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                quad_reg[i+1] <= quad_reg[i];
                if (!cz_reg[i][32])
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - lspx_pkg::atan_phase(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + lspx_pkg::atan_phase(i);
                end
            end
        end
    end

    // rotate back by quadrant
    logic signed [32:0] fc_next;
    logic signed [32:0] fs_next;

    always_comb
    begin
        case (quad_reg[NCOR])
            2'd0:
            begin
                fc_next = cx_reg[NCOR];
                fs_next = cy_reg[NCOR];
            end
            2'd1:
            begin
                fc_next = -cy_reg[NCOR];
                fs_next = cx_reg[NCOR];
            end
            2'd2:
            begin
                fc_next = -cx_reg[NCOR];
                fs_next = -cy_reg[NCOR];
            end
            default:
            begin
                fc_next = cy_reg[NCOR];
                fs_next = -cx_reg[NCOR];
            end
        endcase
    end

    logic signed [16:0] dist_s;
    assign dist_s = signed'({1'b0, dist_reg[S_ROT]});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fc_reg <= fc_next;
            fs_reg <= fs_next;
            px_reg <= 50'(fc_reg * dist_s);
            py_reg <= 50'(fs_reg * dist_s);
            pz_reg <= 50'(tanf_reg[S_ROT] * dist_s);
        end
    end

    // round half up, then clamp to the 25-bit range
    function automatic logic signed [24:0] round_sat(input logic signed [49:0] p);
        logic signed [49:0] t;
        logic signed [27:0] v;
        t = (p + 50'sd2097152) >>> 22;
        v = t[27:0];
        if (v > lspx_pkg::POS_MAX)
        begin
            v = lspx_pkg::POS_MAX;
        end
        else if (v < lspx_pkg::POS_MIN)
        begin
            v = lspx_pkg::POS_MIN;
        end
        return v[24:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos_x_reg <= round_sat(px_reg);
            pos_y_reg <= round_sat(py_reg);
            pos_z_reg <= round_sat(pz_reg);
        end
    end

endmodule
